>>> rtl/core/generational_slot_allocator_core_macros.svh
// Assertion macros shared by the slot allocator RTL.
// No dependencies; each file that asserts includes this header.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Clocked check, off while reset is high.
`define GSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define GSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/gsa_pkg.sv
// Shared codes, field widths and the decision struct of the slot allocator.
// No dependencies.
package gsa_pkg;

  localparam int ACTION_W  = 2;
  localparam int HIDX_W    = 10;
  localparam int HVER_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int MAXS_W    = 11;

  localparam logic [MAXS_W-1:0] MAX_SLOTS_RESET = 11'd1024;

  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic                slot_we;
    logic                slot_live;
    logic                pop;
    logic                push;
    logic                fresh;
    logic [STATUS_W-1:0] status;
    logic                is_valid;
  } gsa_dec_t;

endpackage

>>> rtl/core/generational_slot_allocator_core.sv
// Generational handle allocator: one result word for every request word,
// one request per cycle sustained, result loaded into the output register
// at the edge on which the decide stage fires (the accepting edge reads
// the slot table and the free stack, the decide edge decides, writes back and
// loads the output register). Throughput is set by the
// single read and single write port of each table, with a one-entry bypass
// for the write made at the same edge as the next request's read. The
// stall-free rate holds while the output side takes a word each cycle. The
// tables need no clearing pass after reset: the high-water mark and the
// free count bound every entry that is read.
`include "generational_slot_allocator_core_macros.svh"

module generational_slot_allocator_core #(
  parameter int NUM_SLOTS    = 1024,
  parameter int VERSION_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gsa_pkg::ACTION_W-1:0] action,
  input  logic [gsa_pkg::HIDX_W-1:0]   handle_index,
  input  logic [gsa_pkg::HVER_W-1:0]   handle_version,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gsa_pkg::STATUS_W-1:0] status,
  output logic [gsa_pkg::HIDX_W-1:0]   out_index,
  output logic [gsa_pkg::HVER_W-1:0]   out_version,
  output logic                         is_valid,
  input  logic                         cfg_wr_en,
  input  logic [gsa_pkg::MAXS_W-1:0]   cfg_wr_data
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int VER_W = VERSION_BITS;
  localparam int SLOT_W  = VER_W + 1;
  localparam int STACK_W = IDX_W + VER_W;

  // control state
  logic                       s1_valid;
  logic [CNT_W-1:0]           free_count;
  logic [CNT_W-1:0]           high_water;
  logic [gsa_pkg::MAXS_W-1:0] max_slots;
  logic                       fwd_slot_en;
  logic                       fwd_stack_en;

  // request held for the decide cycle
  logic [gsa_pkg::ACTION_W-1:0] s1_action;
  logic [gsa_pkg::HIDX_W-1:0]   s1_index;
  logic [gsa_pkg::HVER_W-1:0]   s1_version;
  logic [IDX_W-1:0]             s1_stack_addr;
  logic [IDX_W-1:0]             s1_slot_addr;

  // bypass of the write made at the request's read edge
  logic [IDX_W-1:0]   fwd_slot_addr;
  logic [SLOT_W-1:0]  fwd_slot_data;
  logic [IDX_W-1:0]   fwd_stack_addr;
  logic [STACK_W-1:0] fwd_stack_data;

  logic               accept;
  logic               s1_fire;
  logic [SLOT_W-1:0]  slot_rdata;
  logic [STACK_W-1:0] stack_rdata;
  logic [SLOT_W-1:0]  slot_cur;
  logic [STACK_W-1:0] stack_cur;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   top_next;
  logic [IDX_W-1:0]   stack_raddr;
  logic [IDX_W-1:0]   stack_waddr;
  logic [SLOT_W-1:0]  slot_wdata;
  logic [STACK_W-1:0] stack_wdata;
  logic               slot_we;
  logic               stack_we;

  gsa_pkg::gsa_dec_t dec;
  logic [IDX_W-1:0]  slot_addr;
  logic [VER_W-1:0]  slot_wver;
  logic [IDX_W-1:0]  new_idx;
  logic [VER_W-1:0]  new_ver;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign accept   = in_valid && in_ready;

  assign s1_slot_addr = IDX_W'(s1_index);

  assign slot_cur  = (fwd_slot_en && (fwd_slot_addr == s1_slot_addr)) ?
                     fwd_slot_data : slot_rdata;
  assign stack_cur = (fwd_stack_en && (fwd_stack_addr == s1_stack_addr)) ?
                     fwd_stack_data : stack_rdata;

  gsa_exec #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W),
    .VER_W     (VER_W)
  ) u_exec (
    .action         (s1_action),
    .handle_index   (s1_index),
    .handle_version (s1_version),
    .slot_live      (slot_cur[VER_W]),
    .slot_ver       (slot_cur[VER_W-1:0]),
    .stack_idx      (stack_cur[STACK_W-1:VER_W]),
    .stack_ver      (stack_cur[VER_W-1:0]),
    .free_count     (free_count),
    .high_water     (high_water),
    .max_slots      (max_slots),
    .dec            (dec),
    .slot_addr      (slot_addr),
    .slot_wver      (slot_wver),
    .new_idx        (new_idx),
    .new_ver        (new_ver)
  );

  always_comb begin
    count_next = free_count;
    if (s1_fire && dec.pop) begin
      count_next = free_count - CNT_W'(1);
    end else if (s1_fire && dec.push) begin
      count_next = free_count + CNT_W'(1);
    end
  end

  // read the top of the stack as it stands after the write at this edge
  assign top_next    = count_next - CNT_W'(1);
  assign stack_raddr = top_next[IDX_W-1:0];
  assign stack_waddr = free_count[IDX_W-1:0];

  assign slot_we     = s1_fire && dec.slot_we;
  assign stack_we    = s1_fire && dec.push;
  assign slot_wdata  = {dec.slot_live, slot_wver};
  // a freed entry carries its new version, so a pop needs no second lookup
  assign stack_wdata = {s1_slot_addr, slot_wver};

  gsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_addr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (IDX_W'(handle_index)),
    .rdata (slot_rdata)
  );

  gsa_ram #(
    .WIDTH (STACK_W),
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (accept),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      free_count   <= '0;
      high_water   <= '0;
      max_slots    <= gsa_pkg::MAX_SLOTS_RESET;
      fwd_slot_en  <= 1'b0;
      fwd_stack_en <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_slots <= cfg_wr_data;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_fire) begin
        free_count <= count_next;
        if (dec.fresh) begin
          high_water <= high_water + CNT_W'(1);
        end
      end
      // tables only change on a fire, so the bypass holds while the word waits
      if (accept) begin
        fwd_slot_en  <= slot_we;
        fwd_stack_en <= stack_we;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action      <= action;
      s1_index       <= handle_index;
      s1_version     <= handle_version;
      s1_stack_addr  <= stack_raddr;
      fwd_slot_addr  <= slot_addr;
      fwd_slot_data  <= slot_wdata;
      fwd_stack_addr <= stack_waddr;
      fwd_stack_data <= stack_wdata;
    end
    if (s1_fire) begin
      status      <= dec.status;
      out_index   <= gsa_pkg::HIDX_W'(new_idx);
      out_version <= gsa_pkg::HVER_W'(new_ver);
      is_valid    <= dec.is_valid;
    end
  end

  `GSA_ASSERT_ALWAYS(a_free_le_hw, rst || (free_count <= high_water), "free count above high-water mark")
  `GSA_ASSERT(a_hw_monotonic, !$past(rst) |-> (high_water >= $past(high_water)), "high-water mark went down")
  `GSA_ASSERT(a_push_count, (s1_fire && dec.push) |=> (free_count == $past(free_count) + CNT_W'(1)), "release did not grow free count")
  `GSA_ASSERT(a_fresh_limit, (s1_fire && dec.fresh) |-> (free_count == '0), "fresh slot opened with freed slots waiting")

endmodule

>>> rtl/core/gsa_ram.sv
// Single write port, single registered read port RAM.
// No dependencies.
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/gsa_exec.sv
// Per-request decision logic: handle check, allocate, release.
// Depends on gsa_pkg for codes, widths and the decision struct.
module gsa_exec #(
  parameter int NUM_SLOTS = 1024,
  parameter int IDX_W     = 10,
  parameter int CNT_W     = 11,
  parameter int VER_W     = 32
) (
  input  logic [gsa_pkg::ACTION_W-1:0] action,
  input  logic [gsa_pkg::HIDX_W-1:0]   handle_index,
  input  logic [gsa_pkg::HVER_W-1:0]   handle_version,
  input  logic                         slot_live,
  input  logic [VER_W-1:0]             slot_ver,
  input  logic [IDX_W-1:0]             stack_idx,
  input  logic [VER_W-1:0]             stack_ver,
  input  logic [CNT_W-1:0]             free_count,
  input  logic [CNT_W-1:0]             high_water,
  input  logic [gsa_pkg::MAXS_W-1:0]   max_slots,
  output gsa_pkg::gsa_dec_t            dec,
  output logic [IDX_W-1:0]             slot_addr,
  output logic [VER_W-1:0]             slot_wver,
  output logic [IDX_W-1:0]             new_idx,
  output logic [VER_W-1:0]             new_ver
);

  localparam int CMP_W = (CNT_W > gsa_pkg::HIDX_W) ? CNT_W : gsa_pkg::HIDX_W;
  localparam int LIM_W = (CNT_W > gsa_pkg::MAXS_W) ? CNT_W : gsa_pkg::MAXS_W;

  logic [IDX_W-1:0] hidx_addr;
  logic             hit;
  logic             below_limit;

  assign hidx_addr = IDX_W'(handle_index);

  // Opened, live and current; the whole 32-bit version must match.
  assign hit = (CMP_W'(handle_index) < CMP_W'(high_water)) && slot_live &&
               (gsa_pkg::HVER_W'(slot_ver) == handle_version);

  assign below_limit = (LIM_W'(high_water) < LIM_W'(max_slots)) &&
                       (high_water < CNT_W'(NUM_SLOTS));

  always_comb begin
    dec        = '0;
    dec.status = gsa_pkg::ST_OK;
    slot_addr  = hidx_addr;
    slot_wver  = slot_ver + VER_W'(1);
    new_idx    = '0;
    new_ver    = '0;
    unique case (action)
      gsa_pkg::ACT_ALLOC: begin
        priority if (free_count != '0) begin
          // reuse the most recently freed slot at its bumped version
          dec.pop       = 1'b1;
          dec.slot_we   = 1'b1;
          dec.slot_live = 1'b1;
          slot_addr     = stack_idx;
          slot_wver     = stack_ver;
          new_idx       = stack_idx;
          new_ver       = stack_ver;
        end else if (below_limit) begin
          dec.fresh     = 1'b1;
          dec.slot_we   = 1'b1;
          dec.slot_live = 1'b1;
          slot_addr     = high_water[IDX_W-1:0];
          slot_wver     = '0;
          new_idx       = high_water[IDX_W-1:0];
        end else begin
          dec.status = gsa_pkg::ST_FULL;
        end
      end
      gsa_pkg::ACT_RELEASE: begin
        if (hit) begin
          dec.slot_we   = 1'b1;
          dec.slot_live = 1'b0;
          dec.push      = (free_count < CNT_W'(NUM_SLOTS));
          dec.is_valid  = 1'b1;
        end else begin
          dec.status = gsa_pkg::ST_INVALID;
        end
      end
      gsa_pkg::ACT_CHECK: begin
        if (hit) begin
          dec.is_valid = 1'b1;
        end else begin
          dec.status = gsa_pkg::ST_INVALID;
        end
      end
      default: begin
        dec.status = gsa_pkg::ST_INVALID;
      end
    endcase
  end

endmodule

>>> dv/generational_slot_allocator_core_tb.sv
// Self-checking bench for generational_slot_allocator_core: directed and random handle traffic.
// A scoreboard class predicts each reply word; needs gsa_pkg and the core RTL only.
`timescale 1ns / 100ps

module generational_slot_allocator_core_tb;

  localparam int SLOT_COUNT = 1024;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_WORDS_PER_PHASE = 64;
  localparam logic [gsa_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [gsa_pkg::ACTION_W-1:0] act;
    logic [gsa_pkg::HIDX_W-1:0]   slot;
    logic [gsa_pkg::HVER_W-1:0]   gen;
  } slot_request_t;

  typedef struct packed {
    logic [gsa_pkg::STATUS_W-1:0] status;
    logic [gsa_pkg::HIDX_W-1:0]   slot;
    logic [gsa_pkg::HVER_W-1:0]   gen;
    logic                         live;
  } slot_reply_t;

  class slot_map_scoreboard;
    bit [gsa_pkg::HVER_W-1:0] ver_tab[SLOT_COUNT];
    bit                       live_tab[SLOT_COUNT];
    bit [gsa_pkg::HIDX_W-1:0] free_stk[SLOT_COUNT];
    int unsigned              free_cnt;
    int unsigned              high_water;
    int unsigned              max_slots = gsa_pkg::MAX_SLOTS_RESET;
    slot_reply_t              reply_q[$];
    int unsigned              fail_count;

    function void set_max_slots(logic [gsa_pkg::MAXS_W-1:0] value);
      max_slots = value;
    endfunction

    function bit handle_live(slot_request_t req);
      if (req.slot >= high_water || !live_tab[req.slot]) return 1'b0;
      return ver_tab[req.slot] == req.gen;
    endfunction

    // Advance the slot map by one accepted request and queue its reply.
    function void take_request(slot_request_t req);
      slot_reply_t rep;
      int unsigned slot_cap;
      rep = '0;
      slot_cap = (max_slots < SLOT_COUNT) ? max_slots : SLOT_COUNT;
      case (req.act)
        gsa_pkg::ACT_ALLOC: begin
          if (free_cnt > 0) begin
            free_cnt--;
            rep.slot = free_stk[free_cnt];
            live_tab[rep.slot] = 1'b1;
            rep.gen = ver_tab[rep.slot];
          end else if (high_water < slot_cap) begin
            rep.slot = gsa_pkg::HIDX_W'(high_water);
            ver_tab[high_water] = '0;
            live_tab[high_water] = 1'b1;
            high_water++;
          end else begin
            rep.status = gsa_pkg::ST_FULL;
          end
        end
        gsa_pkg::ACT_RELEASE: begin
          if (handle_live(req)) begin
            live_tab[req.slot] = 1'b0;
            ver_tab[req.slot] = ver_tab[req.slot] + 1'b1;
            if (free_cnt < SLOT_COUNT) begin
              free_stk[free_cnt] = req.slot;
              free_cnt++;
            end
            rep.live = 1'b1;
          end else begin
            rep.status = gsa_pkg::ST_INVALID;
          end
        end
        gsa_pkg::ACT_CHECK: begin
          if (handle_live(req)) rep.live = 1'b1;
          else rep.status = gsa_pkg::ST_INVALID;
        end
        default: rep.status = gsa_pkg::ST_INVALID;
      endcase
      reply_q.insert(reply_q.size(), rep);
    endfunction

    function void check_reply(slot_reply_t got);
      slot_reply_t want;
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR %0t: unexpected reply word status %0d slot %0d gen %h live %0b",
                   $time, got.status, got.slot, got.gen, got.live);
        return;
      end
      want = reply_q.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.gen !== want.gen || got.live !== want.live) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"ERROR %0t: reply mismatch status %0d/%0d slot %0d/%0d ",
                    "gen %h/%h live %0b/%0b (expected/actual)"}, $time,
                   want.status, got.status, want.slot, got.slot,
                   want.gen, got.gen, want.live, got.live);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [gsa_pkg::ACTION_W-1:0] action;
  logic [gsa_pkg::HIDX_W-1:0]   handle_index;
  logic [gsa_pkg::HVER_W-1:0]   handle_version;
  logic                         out_valid;
  logic                         out_ready;
  logic [gsa_pkg::STATUS_W-1:0] status;
  logic [gsa_pkg::HIDX_W-1:0]   out_index;
  logic [gsa_pkg::HVER_W-1:0]   out_version;
  logic                         is_valid;
  logic                         cfg_wr_en;
  logic [gsa_pkg::MAXS_W-1:0]   cfg_wr_data;

  slot_map_scoreboard sb = new();
  bit send_burst;
  bit take_burst;

  generational_slot_allocator_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .handle_index   (handle_index),
    .handle_version (handle_version),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .out_index      (out_index),
    .out_version    (out_version),
    .is_valid       (is_valid),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly random gaps, with stretches of back-to-back words.
  function automatic int unsigned pick_gap(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_request(input logic [gsa_pkg::ACTION_W-1:0] act,
                              input logic [gsa_pkg::HIDX_W-1:0] slot,
                              input logic [gsa_pkg::HVER_W-1:0] gen);
    int unsigned gap;
    slot_request_t req;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    handle_index   <= slot;
    handle_version <= gen;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    req.act  = act;
    req.slot = slot;
    req.gen  = gen;
    sb.take_request(req);
  endtask

  // Write the limit only once every reply is back and the pipeline has drained.
  task automatic write_slot_limit(input logic [gsa_pkg::MAXS_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.reply_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_max_slots(value);
  endtask

  // Mostly well-formed handle traffic, some stale handles, some raw noise.
  function automatic slot_request_t pick_request();
    slot_request_t req;
    int unsigned roll;
    int live_q[$];
    int dead_q[$];
    int slot;
    roll = $urandom_range(0, 99);
    for (int i = 0; i < sb.high_water; i++) begin
      if (sb.live_tab[i]) live_q.insert(live_q.size(), i);
      else dead_q.insert(dead_q.size(), i);
    end
    req.act  = gsa_pkg::ACT_ALLOC;
    req.slot = gsa_pkg::HIDX_W'($urandom_range(0, SLOT_COUNT - 1));
    req.gen  = $urandom;
    if (roll < 35 || (roll < 85 && live_q.size() == 0 && dead_q.size() == 0)) begin
      req.act = gsa_pkg::ACT_ALLOC;
    end else if (roll < 60 && live_q.size() > 0) begin
      slot = live_q[$urandom_range(0, live_q.size() - 1)];
      req.act  = gsa_pkg::ACT_RELEASE;
      req.slot = gsa_pkg::HIDX_W'(slot);
      req.gen  = sb.ver_tab[slot];
    end else if (roll < 75 && live_q.size() > 0) begin
      slot = live_q[$urandom_range(0, live_q.size() - 1)];
      req.act  = gsa_pkg::ACT_CHECK;
      req.slot = gsa_pkg::HIDX_W'(slot);
      req.gen  = sb.ver_tab[slot];
    end else if (roll < 85) begin
      req.act = $urandom_range(0, 1) ? gsa_pkg::ACT_RELEASE : gsa_pkg::ACT_CHECK;
      if (dead_q.size() > 0 && (live_q.size() == 0 || $urandom_range(0, 1))) begin
        // dead slot, current or previous generation
        slot = dead_q[$urandom_range(0, dead_q.size() - 1)];
        req.gen = sb.ver_tab[slot] - $urandom_range(0, 1);
      end else begin
        // live slot, one generation bit flipped
        slot = live_q[$urandom_range(0, live_q.size() - 1)];
        req.gen = sb.ver_tab[slot] ^ (32'd1 << $urandom_range(0, 31));
      end
      req.slot = gsa_pkg::HIDX_W'(slot);
    end else begin
      req.act = gsa_pkg::ACTION_W'($urandom_range(0, 3));
    end
    return req;
  endfunction

  initial begin
    slot_reply_t got;
    int unsigned gap;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = pick_gap(take_burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.status = status;
      got.slot   = out_index;
      got.gen    = out_version;
      got.live   = is_valid;
      sb.check_reply(got);
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    slot_request_t req;
    logic [gsa_pkg::MAXS_W-1:0] phase_limits[6];
    phase_limits   = '{11'd8, 11'd2047, 11'd3, 11'd0, 11'd1024, 11'd1};
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = gsa_pkg::ACT_ALLOC;
    handle_index   = '0;
    handle_version = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // single-slot limit: unopened, fresh, full, stale, dead and recycled handles
    write_slot_limit(11'd1);
    send_request(gsa_pkg::ACT_CHECK, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_RELEASE, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd1023, 32'hFFFF_FFFF);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_CHECK, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_CHECK, 10'd0, 32'hFFFF_FFFF);
    send_request(gsa_pkg::ACT_CHECK, 10'd1023, 32'd0);
    send_request(gsa_pkg::ACT_RELEASE, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_CHECK, 10'd0, 32'd1);
    send_request(gsa_pkg::ACT_RELEASE, 10'd0, 32'd1);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(ACT_UNUSED, 10'd1023, 32'hFFFF_FFFF);
    send_request(gsa_pkg::ACT_RELEASE, 10'd0, 32'd1);

    // zero limit: only the free stack can serve
    write_slot_limit(11'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_RELEASE, 10'd0, 32'd2);

    write_slot_limit(11'd2047);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);

    // limit dropped below the high-water mark
    write_slot_limit(11'd2);
    send_request(gsa_pkg::ACT_RELEASE, 10'd1, 32'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_ALLOC, 10'd0, 32'd0);
    send_request(gsa_pkg::ACT_CHECK, 10'd3, 32'd0);
    send_request(ACT_UNUSED, 10'd0, 32'd0);

    foreach (phase_limits[p]) begin
      write_slot_limit(phase_limits[p]);
      repeat (RANDOM_WORDS_PER_PHASE) begin
        req = pick_request();
        send_request(req.act, req.slot, req.gen);
      end
    end

    in_valid <= 1'b0;
    while (sb.reply_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
